// File: design/pgbt_pkg.sv
// Package for the point grid binning block: sizes, configuration register codes,
// controller states and the command and status types passed between the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package pgbt_pkg;

  localparam int GRID_SIZE   = 8;
  localparam int COUNT_WIDTH = 8;

  localparam int COORD_W    = 12;
  localparam int CFG_W      = 8;
  localparam int ROW_IDX_W  = 4;
  localparam int ROW_BITS_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int ROW_W     = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int LINE_W    = GRID_SIZE * COUNT_WIDTH;
  localparam int CMP_W     = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int DIV_CNT_W = $clog2(COORD_W);

  localparam logic [CFG_W-1:0] CELL_WIDTH_RESET = 8'd20;
  localparam logic [CFG_W-1:0] MIN_POINTS_RESET = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_WIDTH = 1'b0,
    CFG_MIN_POINTS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_UPDATE,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic point_read;
    logic point_write;
    logic emit_read;
    logic emit_load;
    logic emit_next;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_grid;
    logic out_taken;
    logic emit_last;
  } status_t;

endpackage

// File: design/pgbt_div.sv
// Iterative restoring divider: one quotient bit per cycle for a coordinate
// divided by the cell width. Depends on pgbt_pkg.
`timescale 1ns / 1ps

module pgbt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pgbt_pkg::COORD_W-1:0] dividend,
  input  logic [pgbt_pkg::CFG_W-1:0]   divisor,
  output logic [pgbt_pkg::COORD_W-1:0] quotient,
  output logic                        done
);

  logic                          busy;
  logic [pgbt_pkg::DIV_CNT_W-1:0] cnt;
  logic [pgbt_pkg::CFG_W-1:0]     rem;
  logic [pgbt_pkg::CFG_W:0]       shifted;
  logic                          fits;

  always_comb begin
    shifted = {rem, quotient[pgbt_pkg::COORD_W-1]};
    fits    = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pgbt_pkg::DIV_CNT_W'(pgbt_pkg::COORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= pgbt_pkg::CFG_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[pgbt_pkg::CFG_W-1:0];
      end
      quotient <= {quotient[pgbt_pkg::COORD_W-2:0], fits};
    end
  end

endmodule

// File: design/pgbt_datapath.sv
// Datapath: configuration registers, two coordinate dividers, the row-wide
// counter memory with per-row valid bits, and the output register.
// Depends on pgbt_pkg and pgbt_div.
`timescale 1ns / 1ps

module pgbt_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  pgbt_pkg::cmd_t                   cmd,
  output pgbt_pkg::status_t                status,
  input  logic [pgbt_pkg::COORD_W-1:0]     x,
  input  logic [pgbt_pkg::COORD_W-1:0]     y,
  input  logic                             cfg_write,
  input  logic [pgbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgbt_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pgbt_pkg::ROW_IDX_W-1:0]   row_index,
  output logic [pgbt_pkg::ROW_BITS_W-1:0]  row_bits,
  output logic                             last
);

  logic [pgbt_pkg::CFG_W-1:0]   cell_width;
  logic [pgbt_pkg::CFG_W-1:0]   min_points;
  logic [pgbt_pkg::CFG_W-1:0]   divisor;
  logic [pgbt_pkg::COORD_W-1:0] qx;
  logic [pgbt_pkg::COORD_W-1:0] qy;
  logic                         done_x;
  logic                         done_y;
  logic [pgbt_pkg::ROW_W-1:0]   qcol;
  logic [pgbt_pkg::ROW_W-1:0]   qrow;
  logic [pgbt_pkg::ROW_W-1:0]   emit_row;
  logic [pgbt_pkg::ROW_W-1:0]   raddr;
  logic [pgbt_pkg::LINE_W-1:0]  mem [pgbt_pkg::GRID_SIZE];
  logic [pgbt_pkg::LINE_W-1:0]  rd_data;
  logic [pgbt_pkg::LINE_W-1:0]  row_cur;
  logic [pgbt_pkg::LINE_W-1:0]  row_new;
  logic [pgbt_pkg::GRID_SIZE-1:0] row_valid;
  logic [pgbt_pkg::GRID_SIZE-1:0] hit;
  logic                         row_ok;
  logic [pgbt_pkg::COUNT_WIDTH-1:0] lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width <= pgbt_pkg::CELL_WIDTH_RESET;
      min_points <= pgbt_pkg::MIN_POINTS_RESET;
    end else if (cfg_write) begin
      case (pgbt_pkg::cfg_reg_t'(cfg_index))
        pgbt_pkg::CFG_CELL_WIDTH: cell_width <= cfg_data;
        pgbt_pkg::CFG_MIN_POINTS: min_points <= cfg_data;
        default: ;
      endcase
    end
  end

  // A cell width of zero is treated as one.
  assign divisor = (cell_width == '0) ? pgbt_pkg::CFG_W'(1) : cell_width;

  pgbt_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept),
    .dividend (x),
    .divisor  (divisor),
    .quotient (qx),
    .done     (done_x)
  );

  pgbt_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept),
    .dividend (y),
    .divisor  (divisor),
    .quotient (qy),
    .done     (done_y)
  );

  assign qcol  = qx[pgbt_pkg::ROW_W-1:0];
  assign qrow  = qy[pgbt_pkg::ROW_W-1:0];
  assign raddr = cmd.emit_read ? emit_row : qrow;

  always_ff @(posedge clk) begin
    if (cmd.point_read || cmd.emit_read) begin
      rd_data <= mem[raddr];
    end
    if (cmd.point_write) begin
      mem[qrow] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_done) begin
      row_valid <= '0;
    end else if (cmd.point_write) begin
      row_valid[qrow] <= 1'b1;
    end
  end

  always_comb begin
    row_ok  = cmd.emit_load ? row_valid[emit_row] : row_valid[qrow];
    row_cur = row_ok ? rd_data : '0;
    row_new = row_cur;
    hit     = '0;
    lane    = '0;
    for (int c = 0; c < pgbt_pkg::GRID_SIZE; c++) begin
      lane = row_cur[c*pgbt_pkg::COUNT_WIDTH +: pgbt_pkg::COUNT_WIDTH];
      if ((pgbt_pkg::ROW_W'(c) == qcol) && (lane != '1)) begin
        row_new[c*pgbt_pkg::COUNT_WIDTH +: pgbt_pkg::COUNT_WIDTH] =
          lane + pgbt_pkg::COUNT_WIDTH'(1);
      end
      hit[c] = pgbt_pkg::CMP_W'(lane) >= pgbt_pkg::CMP_W'(min_points);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_done) begin
      emit_row <= '0;
    end else if (cmd.emit_next) begin
      emit_row <= emit_row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      row_index <= pgbt_pkg::ROW_IDX_W'(emit_row);
      row_bits  <= pgbt_pkg::ROW_BITS_W'(hit);
      last      <= status.emit_last;
    end
  end

  always_comb begin
    status.div_done  = done_x & done_y;
    status.in_grid   = (qx < pgbt_pkg::COORD_W'(pgbt_pkg::GRID_SIZE)) &&
                       (qy < pgbt_pkg::COORD_W'(pgbt_pkg::GRID_SIZE));
    status.out_taken = out_valid && !out_stall;
    status.emit_last = emit_row == pgbt_pkg::ROW_W'(pgbt_pkg::GRID_SIZE - 1);
  end

endmodule

// File: design/pgbt_ctrl.sv
// Controller state machine: sequences the divide, counter update and row
// emission steps of one request. Depends on pgbt_pkg.
`timescale 1ns / 1ps

module pgbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              action,
  output logic              in_stall,
  input  pgbt_pkg::status_t status,
  output pgbt_pkg::cmd_t    cmd
);

  pgbt_pkg::state_t state;
  pgbt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      pgbt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = action ? pgbt_pkg::ST_EMIT_READ : pgbt_pkg::ST_DIVIDE;
        end
      end
      pgbt_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = status.in_grid ? pgbt_pkg::ST_READ : pgbt_pkg::ST_IDLE;
        end
      end
      pgbt_pkg::ST_READ: begin
        cmd.point_read = 1'b1;
        state_next     = pgbt_pkg::ST_UPDATE;
      end
      pgbt_pkg::ST_UPDATE: begin
        cmd.point_write = 1'b1;
        state_next      = pgbt_pkg::ST_IDLE;
      end
      pgbt_pkg::ST_EMIT_READ: begin
        cmd.emit_read = 1'b1;
        state_next    = pgbt_pkg::ST_EMIT_LOAD;
      end
      pgbt_pkg::ST_EMIT_LOAD: begin
        cmd.emit_load = 1'b1;
        state_next    = pgbt_pkg::ST_EMIT_OUT;
      end
      pgbt_pkg::ST_EMIT_OUT: begin
        if (status.out_taken) begin
          if (status.emit_last) begin
            cmd.emit_done = 1'b1;
            state_next    = pgbt_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = pgbt_pkg::ST_EMIT_READ;
          end
        end
      end
      default: begin
        state_next = pgbt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/point_grid_bin_threshold.sv
// Top level of the point grid binning block: joins the controller and the datapath.
// Depends on pgbt_pkg, pgbt_ctrl and pgbt_datapath.
//
// Each input request carries action, x and y. With action 0 the point is
// divided by cell_width in both coordinates and, if it lands inside the grid,
// the counter of its cell goes up by one and stops at its largest value.
// With action 1 the block sends GRID_SIZE output requests, row 0 first, each
// with row_index, row_bits (bit i set where column i reached min_points) and
// last on the final row, and then clears every counter.
// An add-point request occupies the block from acceptance to the next
// acceptance: first the bit-serial dividers, then the read and write of the
// counter row. A point outside the grid skips the read and the write.
// A finish request reads each row from the counter memory once, loads it
// into the output register and moves on to the next row once it is taken;
// a high out_stall holds the row in the output register until it is taken.
// No new input request is accepted until the last row has been taken.
// Synchronous reset clears all counters at once, empties the output register
// and loads cell_width 20 and min_points 3. Configuration writes through
// cfg_write, cfg_index and cfg_data take effect at the next clock edge.
`timescale 1ns / 1ps

module point_grid_bin_threshold (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             action,
  input  logic [pgbt_pkg::COORD_W-1:0]     x,
  input  logic [pgbt_pkg::COORD_W-1:0]     y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pgbt_pkg::ROW_IDX_W-1:0]   row_index,
  output logic [pgbt_pkg::ROW_BITS_W-1:0]  row_bits,
  output logic                             last,
  input  logic                             cfg_write,
  input  logic [pgbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgbt_pkg::CFG_W-1:0]       cfg_data
);

  pgbt_pkg::cmd_t    cmd;
  pgbt_pkg::status_t status;

  pgbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pgbt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .x         (x),
    .y         (y),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last      (last)
  );

endmodule

// File: design/pgbt_checker.sv
// Port-level checks for the point grid binning block and the bind that
// attaches them to the top level. Depends on pgbt_pkg.
`timescale 1ns / 1ps

module pgbt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [pgbt_pkg::ROW_IDX_W-1:0]   row_index,
  input logic [pgbt_pkg::ROW_BITS_W-1:0]  row_bits,
  input logic                             last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_index) &&
                               $stable(row_bits) && $stable(last))
    else $error("stalled output request changed");

  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a row is pending");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (row_index == pgbt_pkg::ROW_IDX_W'(pgbt_pkg::GRID_SIZE - 1))))
    else $error("last flag does not match the final row");

  a_unused_columns: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((row_bits >> pgbt_pkg::GRID_SIZE) == '0))
    else $error("row bits set beyond the grid");

  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !in_stall && !out_valid)
    else $error("block not ready after the final row");

endmodule

bind point_grid_bin_threshold pgbt_checker u_pgbt_checker (.*);

// File: test/tb_point_grid_bin_threshold.sv
// Self-checking testbench for point_grid_bin_threshold: drives point and finish requests,
// predicts the emitted bitmap rows from its own copy of the cell counters, and checks them.
// Depends on pgbt_pkg and point_grid_bin_threshold.
`timescale 1ns / 1ps

module tb_point_grid_bin_threshold;
  import pgbt_pkg::*;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_FINISH = 1'b1;
  localparam int   GRID_CELLS = GRID_SIZE * GRID_SIZE;
  localparam int   COORD_MAX  = (1 << COORD_W) - 1;
  localparam int   SETTLE_CYCLES = 24;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } grid_req_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]  row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last;
  } grid_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  action = ACT_ADD;
  logic [COORD_W-1:0]    x = '0;
  logic [COORD_W-1:0]    y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ROW_IDX_W-1:0]  row_index;
  logic [ROW_BITS_W-1:0] row_bits;
  logic                  last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  point_grid_bin_threshold DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .x(x),
    .y(y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_index(row_index),
    .row_bits(row_bits),
    .last(last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [COUNT_WIDTH-1:0] grid_counts [GRID_CELLS];
  logic [CFG_W-1:0]       grid_cell_width = CELL_WIDTH_RESET;
  logic [CFG_W-1:0]       grid_min_points = MIN_POINTS_RESET;

  grid_req_t pending_reqs [$];
  grid_row_t expected_rows [$];

  int  reqs_queued = 0;
  int  reqs_accepted = 0;
  int  finishes_seen = 0;
  int  rows_checked = 0;
  int  settings_used = 0;
  int  mismatches = 0;
  logic req_taken = 1'b0;
  int  gap_left = 0;
  int  burst_left = 0;
  int  hold_left = 0;
  int  free_left = 0;
  int  stall_pick;
  logic long_hold_done = 1'b0;

  initial begin
    foreach (grid_counts[i]) grid_counts[i] = '0;
  end

  function automatic int effective_width();
    return (grid_cell_width == 0) ? 1 : int'(grid_cell_width);
  endfunction

  function automatic void bin_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    int w;
    int col;
    int row;
    int idx;
    w = effective_width();
    col = int'(px) / w;
    row = int'(py) / w;
    if (col < GRID_SIZE && row < GRID_SIZE) begin
      idx = row * GRID_SIZE + col;
      if (grid_counts[idx] != {COUNT_WIDTH{1'b1}}) grid_counts[idx]++;
    end
  endfunction

  function automatic void emit_grid();
    grid_row_t r;
    for (int row = 0; row < GRID_SIZE; row++) begin
      r.row_index = ROW_IDX_W'(row);
      r.row_bits = '0;
      for (int col = 0; col < GRID_SIZE; col++) begin
        if (grid_counts[row * GRID_SIZE + col] >= grid_min_points) r.row_bits[col] = 1'b1;
      end
      r.last = (row == GRID_SIZE - 1);
      expected_rows.push_back(r);
    end
    foreach (grid_counts[i]) grid_counts[i] = '0;
  endfunction

  function automatic int next_gap();
    int pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 58) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // The request driver holds each request until the block takes it.
  always @(negedge clk) begin : request_driver
    grid_req_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (gap_left != 0 || pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        cur = pending_reqs.pop_front();
        in_valid <= 1'b1;
        action <= cur.action;
        x <= cur.x;
        y <= cur.y;
        gap_left = next_gap();
      end
    end
  end

  always @(negedge clk) begin : row_receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!long_hold_done && rows_checked >= 20) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
      end else if (stall_pick < 60) begin
        out_stall <= 1'b0;
        free_left = $urandom_range(20, 80);
      end else if (stall_pick < 93) begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : monitor
    grid_row_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        reqs_accepted++;
        if (action == ACT_FINISH) begin
          emit_grid();
          finishes_seen++;
        end else begin
          bin_point(x, y);
        end
      end
      if (out_valid && !out_stall) begin
        rows_checked++;
        if (expected_rows.size() == 0) begin
          $error("unexpected row: row_index %0d row_bits %h last %0b",
                 row_index, row_bits, last);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (row_index !== want.row_index) begin
            $error("row_index: expected %0d, got %0d", want.row_index, row_index);
            mismatches++;
          end
          if (row_bits !== want.row_bits) begin
            $error("row_bits: expected %h, got %h", want.row_bits, row_bits);
            mismatches++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic queue_request(logic act, int px, int py);
    grid_req_t r;
    r.action = act;
    r.x = COORD_W'(px);
    r.y = COORD_W'(py);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic wait_idle();
    while (reqs_accepted != reqs_queued || expected_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CELL_WIDTH) grid_cell_width = val;
    else grid_min_points = val;
  endtask

  task automatic configure_grid(logic [CFG_W-1:0] width, logic [CFG_W-1:0] threshold);
    write_reg(CFG_CELL_WIDTH, width);
    write_reg(CFG_MIN_POINTS, threshold);
    settings_used++;
  endtask

  // Frames of points, clustered on three hot cells, each but possibly the last closed by a finish.
  task automatic queue_frames(int n_items);
    int w;
    int frame_len;
    int pick;
    int slot;
    int done;
    int hot [3];
    int px;
    int py;
    w = effective_width();
    done = 0;
    while (done < n_items) begin
      frame_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      foreach (hot[i]) hot[i] = $urandom_range(0, GRID_CELLS - 1);
      for (int k = 0; k < frame_len && done < n_items; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          slot = (pick < 60) ? hot[$urandom_range(0, 2)] : $urandom_range(0, GRID_CELLS - 1);
          px = (slot % GRID_SIZE) * w + $urandom_range(0, w - 1);
          py = (slot / GRID_SIZE) * w + $urandom_range(0, w - 1);
        end else if (pick < 95) begin
          if ($urandom_range(0, 1) == 1) begin
            px = $urandom_range(GRID_SIZE * w, COORD_MAX);
            py = $urandom_range(0, COORD_MAX);
          end else begin
            px = $urandom_range(0, COORD_MAX);
            py = $urandom_range(GRID_SIZE * w, COORD_MAX);
          end
        end else begin
          px = $urandom_range(0, COORD_MAX);
          py = $urandom_range(0, COORD_MAX);
        end
        queue_request(ACT_ADD, px, py);
        done++;
      end
      if (done < n_items) begin
        queue_request(ACT_FINISH, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    int sat_cell;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: 20-unit cells, threshold of three.
    queue_request(ACT_ADD, 0, 0);
    queue_request(ACT_ADD, 19, 19);
    queue_request(ACT_ADD, 10, 5);
    queue_request(ACT_ADD, 20, 0);
    queue_request(ACT_ADD, 39, 19);
    queue_request(ACT_ADD, 159, 159);
    queue_request(ACT_ADD, 140, 0);
    queue_request(ACT_ADD, 159, 1);
    queue_request(ACT_ADD, 150, 19);
    queue_request(ACT_ADD, 0, 140);
    queue_request(ACT_ADD, 19, 159);
    queue_request(ACT_ADD, 5, 150);
    queue_request(ACT_ADD, 160, 0);
    queue_request(ACT_ADD, 0, 160);
    queue_request(ACT_ADD, COORD_MAX, COORD_MAX);
    queue_request(ACT_ADD, COORD_MAX, 0);
    queue_request(ACT_FINISH, COORD_MAX, COORD_MAX);
    queue_request(ACT_FINISH, 0, 0);
    settings_used++;
    wait_idle();

    configure_grid(8'd1, 8'd1);
    queue_frames(25);
    wait_idle();

    // A zero width acts as one, and a zero threshold sets every cell.
    configure_grid(8'd0, 8'd0);
    queue_frames(12);
    wait_idle();

    // Drive one cell well past the counter limit.
    configure_grid(8'd255, 8'd255);
    sat_cell = $urandom_range(0, GRID_CELLS - 1);
    repeat (262) begin
      queue_request(ACT_ADD, (sat_cell % GRID_SIZE) * 255 + $urandom_range(0, 254),
                    (sat_cell / GRID_SIZE) * 255 + $urandom_range(0, 254));
    end
    queue_request(ACT_FINISH, 0, 0);
    wait_idle();

    configure_grid(8'd37, 8'd2);
    queue_frames(15);
    wait_idle();

    configure_grid(8'd128, 8'd4);
    queue_frames(12);
    wait_idle();

    repeat (3) begin
      configure_grid(CFG_W'($urandom_range(2, 254)), CFG_W'($urandom_range(1, 5)));
      queue_frames(6);
      wait_idle();
    end

    repeat (40) @(negedge clk);
    $display("Ran %0d requests (%0d finishes) over %0d register settings; %0d rows checked.",
             reqs_accepted, finishes_seen, settings_used, rows_checked);
    $display("Included zero width and threshold, counter saturation and a long output hold.");
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_rows.size() != 0) begin
        $error("%0d expected rows never arrived", expected_rows.size());
      end
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $error("run did not finish in time");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
